### sv/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/bclpd_pkg.sv
// ----------------------------------------------------------------------------
// bclpd_pkg
// Types, codes and helpers for the button click / long press detector.
// ----------------------------------------------------------------------------
package bclpd_pkg;

    localparam int CNT_W  = 16;
    localparam int TICK_W = 8;
    localparam int CFG_W  = 16;
    localparam int ADDR_W = 3;

    // Configuration register indexes.
    typedef enum logic [ADDR_W-1:0] {
        REG_TICK_MS       = 3'd0,
        REG_SCAN_INTERVAL = 3'd1,
        REG_DOUBLE_WINDOW = 3'd2,
        REG_SHORT_HOLD    = 3'd3,
        REG_LONG_HOLD     = 3'd4
    } reg_index_t;

    // Key event codes.
    typedef enum logic [2:0] {
        EV_RELEASED  = 3'd0,
        EV_SINGLE    = 3'd1,
        EV_DOUBLE    = 3'd2,
        EV_SHORT     = 3'd3,
        EV_SHORT_REL = 3'd4,
        EV_LONG      = 3'd5
    } key_event_t;

    // One result beat, scanned in the lowest bit.
    typedef struct packed {
        logic       power_cut;
        logic       shutdown_request;
        logic       power_out_on;
        key_event_t key_event;
        logic       scanned;
    } result_t;

    localparam int RES_W   = $bits(result_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    // Millisecond counter advance, held at all ones instead of wrapping.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [TICK_W-1:0] tick);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + {{(CNT_W + 1 - TICK_W){1'b0}}, tick};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

### sv/button_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// button_click_long_press_detector
// Debounces a sampled button on timer ticks and reports clicks and holds.
// ----------------------------------------------------------------------------
//  Channel   Ports            Beat contents (lowest bit first)
//  input     s_t*             button_level
//  result    m_t*             scanned, key_event[2:0], power_out_on,
//                             shutdown_request, power_cut
//  config    cfg_*            write enable, register index, data
//
// Each tick beat is processed in the cycle it is accepted; its result is
// registered and shows on m_tdata in the next cycle unless the output is
// stalled. One beat per cycle is sustained while m_tready is high. The result
// and skid registers let the input accept one more beat while m_tready is low;
// input ready drops only when both are full. Reset is synchronous and restores
// the register defaults and clears the counters and the machine.
module button_click_long_press_detector
    import bclpd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [0] button_level

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [0] scanned, [3:1] key_event,
                                           // [4] power_out_on,
                                           // [5] shutdown_request, [6] power_cut

    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    typedef enum logic [1:0] {
        ST_UP          = 2'd0,
        ST_DOWN_BOUNCE = 2'd1,
        ST_DOWN        = 2'd2,
        ST_UP_BOUNCE   = 2'd3
    } db_state_t;

    logic [TICK_W-1:0] tick_ms_reg;
    logic [CFG_W-1:0]  scan_interval_reg;
    logic [CFG_W-1:0]  double_window_reg;
    logic [CFG_W-1:0]  short_hold_reg;
    logic [CFG_W-1:0]  long_hold_reg;

    db_state_t         state_reg, state_next;
    key_event_t        event_reg, event_next;
    logic              pending_reg, pending_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  hold_reg, hold_next;
    logic [CNT_W-1:0]  gap_reg, gap_next;

    logic              out_valid_reg;
    result_t           out_reg;
    logic              skid_valid_reg;
    result_t           skid_reg;

    logic              pressed;
    logic              do_scan;
    logic [CNT_W-1:0]  scan_adv, hold_adv, gap_adv;
    result_t           res;
    logic              in_fire, out_fire;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - RES_W){1'b0}}, out_reg};
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;

    always_comb begin
        pressed  = !s_tdata[0];
        scan_adv = sat_add(scan_reg, tick_ms_reg);
        hold_adv = sat_add(hold_reg, tick_ms_reg);
        gap_adv  = sat_add(gap_reg, tick_ms_reg);
        do_scan  = scan_adv > scan_interval_reg;

        state_next   = state_reg;
        event_next   = event_reg;
        pending_next = pending_reg;
        scan_next    = do_scan ? '0 : scan_adv;
        hold_next    = hold_adv;
        gap_next     = gap_adv;

        if (do_scan) begin
            unique case (state_reg)
                ST_UP: begin
                    if (pressed) begin
                        state_next = ST_DOWN_BOUNCE;
                    end else if (pending_reg) begin
                        if (gap_adv > double_window_reg) begin
                            event_next   = EV_SINGLE;
                            pending_next = 1'b0;
                        end
                    end else begin
                        event_next = EV_RELEASED;
                    end
                end
                ST_DOWN_BOUNCE: begin
                    if (pressed) begin
                        state_next = ST_DOWN;
                        hold_next  = '0;
                    end else begin
                        state_next = ST_UP;
                    end
                end
                ST_DOWN: begin
                    if (!pressed) begin
                        state_next = ST_UP_BOUNCE;
                    end else if (hold_adv > long_hold_reg) begin
                        event_next = EV_LONG;
                    end else if (hold_adv > short_hold_reg) begin
                        event_next = EV_SHORT;
                    end
                end
                ST_UP_BOUNCE: begin
                    if (pressed) begin
                        state_next = ST_DOWN;
                    end else begin
                        state_next = ST_UP;
                        hold_next  = '0;
                        if (event_reg == EV_SHORT) begin
                            event_next   = EV_SHORT_REL;
                            pending_next = 1'b0;
                        end else if (event_reg == EV_LONG) begin
                            // A release after a long hold keeps the event.
                            pending_next = 1'b0;
                        end else if (pending_reg) begin
                            event_next   = EV_DOUBLE;
                            pending_next = 1'b0;
                        end else begin
                            pending_next = 1'b1;
                            gap_next     = '0;
                        end
                    end
                end
                default: begin
                    state_next = ST_UP;
                end
            endcase
        end

        res.scanned          = do_scan;
        res.key_event        = event_next;
        res.power_out_on     = do_scan && (event_next == EV_SINGLE);
        res.shutdown_request = do_scan && (event_next == EV_SHORT_REL);
        res.power_cut        = do_scan && (event_next == EV_LONG);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_ms_reg       <= TICK_W'(5);
            scan_interval_reg <= CFG_W'(10);
            double_window_reg <= CFG_W'(200);
            short_hold_reg    <= CFG_W'(2000);
            long_hold_reg     <= CFG_W'(5000);
            state_reg         <= ST_UP;
            event_reg         <= EV_RELEASED;
            pending_reg       <= 1'b0;
            scan_reg          <= '0;
            hold_reg          <= '0;
            gap_reg           <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_TICK_MS:       tick_ms_reg       <= cfg_wdata[TICK_W-1:0];
                    REG_SCAN_INTERVAL: scan_interval_reg <= cfg_wdata;
                    REG_DOUBLE_WINDOW: double_window_reg <= cfg_wdata;
                    REG_SHORT_HOLD:    short_hold_reg    <= cfg_wdata;
                    REG_LONG_HOLD:     long_hold_reg     <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (in_fire) begin
                state_reg   <= state_next;
                event_reg   <= event_next;
                pending_reg <= pending_next;
                scan_reg    <= scan_next;
                hold_reg    <= hold_next;
                gap_reg     <= gap_next;
            end

            // Output stage: the skid entry drains first, new beats follow.
            if (skid_valid_reg) begin
                if (out_fire) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (in_fire) begin
                if (!out_valid_reg || out_fire) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/bclpd_checker.sv
// ----------------------------------------------------------------------------
// bclpd_checker
// Port-level checks for the button click / long press detector.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bclpd_checker
    import bclpd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    logic stalled;

    assign stalled = m_tvalid && !m_tready;

    // Pulses only come out of a tick on which the machine ran.
    `ASSERT_IMPLY(a_pulse_needs_scan, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[6:4] == 3'b000)

    // The power-on and power-cut pulses agree with the event code in the same beat.
    `ASSERT_IMPLY(a_on_is_single, aclk, aresetn, m_tvalid && m_tdata[4], m_tdata[3:1] == EV_SINGLE)

    `ASSERT_IMPLY(a_cut_is_long, aclk, aresetn, m_tvalid && m_tdata[6], m_tdata[3:1] == EV_LONG)

    // A result beat that is not taken stays on the bus unchanged.
    `ASSERT_NEXT(a_hold_stalled, aclk, aresetn && stalled, m_tvalid && $stable(m_tdata))

    // Reset leaves no result pending and the input open.
    `ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind button_click_long_press_detector bclpd_checker u_bclpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/button_click_long_press_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_click_long_press_detector_tb
// Self-checking bench: ticks carrying the button level are streamed in under
// several timing settings, and every result beat is compared field by field
// with an in-bench model of the debounce machine, its counters and pulses.
// ----------------------------------------------------------------------------
module button_click_long_press_detector_tb;
    import bclpd_pkg::*;

    localparam int          HALF_PERIOD     = 10;
    localparam int          RESET_CYCLES    = 5;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          TIMEOUT_NS      = 20_000_000;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          ITEMS_PER_PHASE = 75;
    localparam int          MAX_RUN         = 120;
    localparam int          LAST_INDEX      = (1 << ADDR_W) - 1;
    localparam int unsigned COUNT_TOP       = (1 << CNT_W) - 1;
    localparam logic        LEVEL_DOWN      = 1'b0;
    localparam logic        LEVEL_UP        = 1'b1;

    typedef enum logic [1:0] {
        KEY_UP             = 2'd0,
        KEY_PRESS_BOUNCE   = 2'd1,
        KEY_PRESSED        = 2'd2,
        KEY_RELEASE_BOUNCE = 2'd3
    } btn_state_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;   // [0] button_level
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;          // [0] scanned, [3:1] key_event,
                                           // [4] power_out_on,
                                           // [5] shutdown_request, [6] power_cut
    logic                cfg_we    = 1'b0;
    logic [ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    // Model copy of the timing registers, at their reset values.
    logic [TICK_W-1:0]   ms_per_tick = 8'd5;
    logic [CFG_W-1:0]    scan_limit  = 16'd10;
    logic [CFG_W-1:0]    window_ms   = 16'd200;
    logic [CFG_W-1:0]    short_ms    = 16'd2000;
    logic [CFG_W-1:0]    long_ms     = 16'd5000;

    // Model copy of the detector state.
    btn_state_t          btn_state     = KEY_UP;
    key_event_t          event_now     = EV_RELEASED;
    logic                click_waiting = 1'b0;
    logic [CNT_W-1:0]    scan_ms       = '0;
    logic [CNT_W-1:0]    hold_ms       = '0;
    logic [CNT_W-1:0]    gap_ms        = '0;

    logic                pending_levels[$];
    result_t             expected_results[$];
    logic                level_taken  = 1'b0;
    logic                sender_hold  = 1'b0;
    logic                src_busy     = 1'b1;
    logic                sink_busy    = 1'b1;
    int                  src_gap      = 0;
    int                  sink_stall   = 0;
    int                  mismatches   = 0;
    int                  results_seen = 0;

    button_click_long_press_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] add_ms(input logic [CNT_W-1:0] count);
        int unsigned total;
        total = count + ms_per_tick;
        if (total > COUNT_TOP) begin
            total = COUNT_TOP;
        end
        return total[CNT_W-1:0];
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Advances the model by one tick and queues the beat it should produce.
    task automatic predict_tick(input logic level);
        logic    pressed;
        result_t r;
        pressed = (level == LEVEL_DOWN);
        r       = '0;
        scan_ms = add_ms(scan_ms);
        hold_ms = add_ms(hold_ms);
        gap_ms  = add_ms(gap_ms);
        if (scan_ms > scan_limit) begin
            case (btn_state)
                KEY_UP: begin
                    if (pressed) begin
                        btn_state = KEY_PRESS_BOUNCE;
                    end else if (click_waiting) begin
                        if (gap_ms > window_ms) begin
                            event_now     = EV_SINGLE;
                            click_waiting = 1'b0;
                        end
                    end else begin
                        event_now = EV_RELEASED;
                    end
                end
                KEY_PRESS_BOUNCE: begin
                    if (pressed) begin
                        btn_state = KEY_PRESSED;
                        hold_ms   = '0;
                    end else begin
                        btn_state = KEY_UP;
                    end
                end
                KEY_PRESSED: begin
                    if (!pressed) begin
                        btn_state = KEY_RELEASE_BOUNCE;
                    end else if (hold_ms > long_ms) begin
                        event_now = EV_LONG;
                    end else if (hold_ms > short_ms) begin
                        event_now = EV_SHORT;
                    end
                end
                default: begin
                    if (pressed) begin
                        btn_state = KEY_PRESSED;
                    end else begin
                        btn_state = KEY_UP;
                        if (event_now == EV_SHORT) begin
                            event_now     = EV_SHORT_REL;
                            click_waiting = 1'b0;
                        end else if (event_now == EV_LONG) begin
                            // Releasing a long hold drops any pending click.
                            click_waiting = 1'b0;
                        end else if (click_waiting) begin
                            event_now     = EV_DOUBLE;
                            click_waiting = 1'b0;
                        end else begin
                            click_waiting = 1'b1;
                            gap_ms        = '0;
                        end
                        hold_ms = '0;
                    end
                end
            endcase
            r.scanned          = 1'b1;
            r.power_out_on     = (event_now == EV_SINGLE);
            r.shutdown_request = (event_now == EV_SHORT_REL);
            r.power_cut        = (event_now == EV_LONG);
            scan_ms            = '0;
        end
        r.key_event = event_now;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("result beat %0d: %s expected %0h, got %0h",
                     results_seen, what, want, got);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            report_mismatch(what, want, got);
        end
    endtask

    // Sender: one beat at a time, with random gaps after accepted beats.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || level_taken) begin
            level_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (!sender_hold && pending_levels.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, pending_levels.pop_front()};
                src_gap  = src_busy ? idle_length() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sink_busy && $urandom_range(0, 99) < 30) begin
                sink_stall = idle_length();
            end
        end
    end

    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata[0]);
                level_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[RES_W-1:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat, tdata", '0, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("scanned", 8'(want.scanned), 8'(got.scanned));
                    check_field("key_event", 8'(want.key_event), 8'(got.key_event));
                    check_field("power_out_on", 8'(want.power_out_on),
                                8'(got.power_out_on));
                    check_field("shutdown_request", 8'(want.shutdown_request),
                                8'(got.shutdown_request));
                    check_field("power_cut", 8'(want.power_cut), 8'(got.power_cut));
                end
                results_seen++;
            end
        end
    end

    task automatic write_register(input logic [ADDR_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_TICK_MS:       ms_per_tick = value[TICK_W-1:0];
            REG_SCAN_INTERVAL: scan_limit  = value;
            REG_DOUBLE_WINDOW: window_ms   = value;
            REG_SHORT_HOLD:    short_ms    = value;
            REG_LONG_HOLD:     long_ms     = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Called only while the block is idle: loads a timing setting and picks
    // how busy both sides of the stream are for the coming phase.
    task automatic begin_phase(input int tick, input int scan, input int window,
                               input int short_hold, input int long_hold);
        write_register(REG_TICK_MS, {8'($urandom_range(0, 255)), 8'(tick)});
        write_register(REG_SCAN_INTERVAL, CFG_W'(scan));
        write_register(REG_DOUBLE_WINDOW, CFG_W'(window));
        write_register(REG_SHORT_HOLD, CFG_W'(short_hold));
        write_register(REG_LONG_HOLD, CFG_W'(long_hold));
        // Unused indexes must not disturb any register.
        write_register(ADDR_W'($urandom_range(REG_LONG_HOLD + 1, LAST_INDEX)),
                       CFG_W'($urandom));
        src_busy  = ($urandom_range(0, 3) != 0);
        sink_busy = ($urandom_range(0, 3) != 0);
    endtask

    task automatic queue_levels(input string levels);
        foreach (levels[i]) begin
            pending_levels.push_back(levels[i] == "1");
        end
    endtask

    // Alternating press and release runs sized from the current timing, so
    // that taps, double taps and holds past both limits can all occur, mixed
    // with one- and two-tick bounces.
    task automatic queue_button_activity(input int count);
        int   added;
        int   run;
        int   unit;
        int   tick_div;
        int   r;
        logic level;
        added    = 0;
        level    = 1'($urandom_range(0, 1));
        tick_div = (ms_per_tick == 0) ? 1 : ms_per_tick;
        unit     = scan_limit / tick_div + 1;
        while (added < count) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                run = $urandom_range(1, 2);
            end else if (r < 60) begin
                run = unit * $urandom_range(2, 4);
            end else if (level == LEVEL_DOWN) begin
                run = $urandom_range(1, (short_ms > long_ms ? short_ms : long_ms) / tick_div
                                        + 4 * unit);
            end else begin
                run = $urandom_range(1, window_ms / tick_div + 4 * unit);
            end
            if (run > MAX_RUN) begin
                run = MAX_RUN;
            end
            if (run > count - added) begin
                run = count - added;
            end
            repeat (run) pending_levels.push_back(level);
            added += run;
            level = ~level;
        end
    endtask

    task automatic wait_drained();
        while (pending_levels.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int tick;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset timing: the scan runs only on every third tick.
        queue_levels("1011");
        wait_drained();

        // Scan on every tick: bounce, re-press during release bounce, short
        // then long hold, long-hold release, double click, single click.
        begin_phase(10, 0, 30, 30, 50);
        queue_levels("101001000001110011001100111111");
        wait_drained();

        // A zero tick leaves every counter where it is, so no scan happens.
        begin_phase(0, 0, COUNT_TOP, COUNT_TOP, COUNT_TOP);
        queue_button_activity(10);
        wait_drained();

        // Counters pin at all ones; an interval of all ones is never exceeded.
        begin_phase(255, COUNT_TOP, 0, 0, 0);
        queue_button_activity(20);
        wait_drained();

        // Hold and gap counters saturate and still cross limits just below.
        begin_phase(255, 0, COUNT_TOP - 1, COUNT_TOP - 2, COUNT_TOP - 1);
        repeat (262) pending_levels.push_back(LEVEL_DOWN);
        queue_levels("1110011");
        repeat (262) pending_levels.push_back(LEVEL_UP);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                begin_phase(1, 0, 0, 0, 0);
            end else begin
                tick = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 40);
                begin_phase(tick, $urandom_range(0, 3 * tick), $urandom_range(0, 12 * tick),
                            $urandom_range(0, 25 * tick), $urandom_range(0, 50 * tick));
            end
            queue_button_activity(ITEMS_PER_PHASE);
            if (phase == 2) begin
                // Stop sending midway until the block has delivered everything.
                while (pending_levels.size() > ITEMS_PER_PHASE / 2) begin
                    @(posedge aclk);
                end
                sender_hold = 1'b1;
                while (s_tvalid || expected_results.size() != 0) begin
                    @(posedge aclk);
                end
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                sender_hold = 1'b0;
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("button_click_long_press_detector test passed");
        end else begin
            $display("button_click_long_press_detector test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("button_click_long_press_detector test failed");
        $finish;
    end

endmodule
